### hdl/tcdq_pkg.sv
// Package with widths, request and status codes and the cell control type of the deque.
`default_nettype none
package tcdq_pkg;
    localparam int DEPTH_DEF = 16;
    localparam int ID_W      = 32;
    localparam int REQ_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int TDATA_W   = 40;

    localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SERVE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_HOLD       = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [OP_W-1:0] OP_PUSH_REAR  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP        = 3'd3;
    localparam logic [OP_W-1:0] OP_LOAD       = 3'd4;
    localparam logic [OP_W-1:0] OP_STEP       = 3'd5;

    typedef struct packed {
        logic [OP_W-1:0]        op;
        logic signed [ID_W-1:0] id;
        logic                   urg;
    } cell_ctrl_t;
endpackage
`default_nettype wire

### hdl/tcdq_cell.sv
// One cell of the deque chain: holds one entry and one stage of the search result wave.
`default_nettype none
module tcdq_cell (
    input  wire logic                          clk,
    input  wire tcdq_pkg::cell_ctrl_t          ctrl,
    input  wire logic                          occupied,
    input  wire logic                          is_tail,
    input  wire logic signed [tcdq_pkg::ID_W-1:0] left_id,
    input  wire logic                          left_urg,
    input  wire logic signed [tcdq_pkg::ID_W-1:0] right_id,
    input  wire logic                          right_urg,
    input  wire logic                          right_hit,
    input  wire logic                          right_hurg,
    output logic signed [tcdq_pkg::ID_W-1:0]   id,
    output logic                               urg,
    output logic                               hit,
    output logic                               hurg
);
    import tcdq_pkg::*;

    logic signed [ID_W-1:0] id_reg;
    logic                   urg_reg;
    logic                   hit_reg;
    logic                   hurg_reg;

    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            OP_PUSH_FRONT:
            begin
                id_reg  <= left_id;
                urg_reg <= left_urg;
            end
            OP_PUSH_REAR:
            begin
                if (is_tail)
                begin
                    id_reg  <= ctrl.id;
                    urg_reg <= ctrl.urg;
                end
            end
            OP_POP:
            begin
                id_reg  <= right_id;
                urg_reg <= right_urg;
            end
            OP_LOAD:
            begin
                hit_reg  <= occupied && (id_reg == ctrl.id);
                hurg_reg <= urg_reg;
            end
            OP_STEP:
            begin
                if (!hit_reg)
                begin
                    hit_reg  <= right_hit;
                    hurg_reg <= right_hurg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign id   = id_reg;
    assign urg  = urg_reg;
    assign hit  = hit_reg;
    assign hurg = hurg_reg;
endmodule
`default_nettype wire

### hdl/two_class_deque_with_id_search.sv
// Top level of the two-class deque: request decode, occupancy control and the cell chain.
// Add and serve requests give their result in the output register in the cycle after acceptance,
// and a new request is taken every cycle while the result side keeps up.
// A search compares the key with every occupied entry, then shifts the match wave to the head
// until its walk count runs out and registers the result; no request is taken until then.
// Reset clears occupancy, the state and the output valid; entry storage holds no reset value.
`default_nettype none
module two_class_deque_with_id_search #(
    parameter int DEPTH = tcdq_pkg::DEPTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // Fields from bit 0: req_type[1:0], entry_id[33:2], urgent[34], zero fill.
    input  wire logic [tcdq_pkg::TDATA_W-1:0]   s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // Fields from bit 0: status[1:0], out_id[33:2], out_urgent[34], zero fill.
    output logic [tcdq_pkg::TDATA_W-1:0]        m_tdata
);
    import tcdq_pkg::*;

    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam logic S_IDLE = 1'b0;
    localparam logic S_WALK = 1'b1;

    logic                   state_reg, state_next;
    logic [OCC_W-1:0]       occ_reg, occ_next;
    logic [IDX_W-1:0]       cnt_reg, cnt_next;
    logic signed [ID_W-1:0] key_reg, key_next;
    logic                   ov_reg, ov_next;
    logic [STATUS_W-1:0]    ost_reg, ost_next;
    logic signed [ID_W-1:0] oid_reg, oid_next;
    logic                   ourg_reg, ourg_next;

    logic [REQ_W-1:0]       in_req;
    logic signed [ID_W-1:0] in_id;
    logic                   in_urg;
    logic                   accept;
    logic                   full;
    logic                   empty;
    cell_ctrl_t             ctrl;

    logic signed [ID_W-1:0] c_id   [DEPTH];
    logic                   c_urg  [DEPTH];
    logic                   c_hit  [DEPTH];
    logic                   c_hurg [DEPTH];

    assign in_req   = s_tdata[1:0];
    assign in_id    = s_tdata[33:2];
    assign in_urg   = s_tdata[34];
    assign s_tready = (state_reg == S_IDLE) && (!ov_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign full     = (occ_reg == OCC_W'(DEPTH));
    assign empty    = (occ_reg == '0);

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic signed [ID_W-1:0] l_id, r_id;
            logic                   l_urg, r_urg, r_hit, r_hurg;
            if (gi == 0)
            begin : g_first
                assign l_id  = ctrl.id;
                assign l_urg = ctrl.urg;
            end
            else
            begin : g_mid
                assign l_id  = c_id[gi-1];
                assign l_urg = c_urg[gi-1];
            end
            if (gi == DEPTH - 1)
            begin : g_last
                assign r_id   = '0;
                assign r_urg  = 1'b0;
                assign r_hit  = 1'b0;
                assign r_hurg = 1'b0;
            end
            else
            begin : g_inner
                assign r_id   = c_id[gi+1];
                assign r_urg  = c_urg[gi+1];
                assign r_hit  = c_hit[gi+1];
                assign r_hurg = c_hurg[gi+1];
            end
            tcdq_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .occupied   (occ_reg > OCC_W'(gi)),
                .is_tail    (occ_reg == OCC_W'(gi)),
                .left_id    (l_id),
                .left_urg   (l_urg),
                .right_id   (r_id),
                .right_urg  (r_urg),
                .right_hit  (r_hit),
                .right_hurg (r_hurg),
                .id         (c_id[gi]),
                .urg        (c_urg[gi]),
                .hit        (c_hit[gi]),
                .hurg       (c_hurg[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        occ_next   = occ_reg;
        cnt_next   = cnt_reg;
        key_next   = key_reg;
        ov_next    = ov_reg && !m_tready;
        ost_next   = ost_reg;
        oid_next   = oid_reg;
        ourg_next  = ourg_reg;
        ctrl.op    = OP_HOLD;
        ctrl.id    = in_id;
        ctrl.urg   = in_urg;
        if (state_reg == S_WALK)
        begin
            if (cnt_reg == '0)
            begin
                ov_next    = 1'b1;
                state_next = S_IDLE;
                if (c_hit[0])
                begin
                    ost_next  = ST_OK;
                    oid_next  = key_reg;
                    ourg_next = c_hurg[0];
                end
                else
                begin
                    ost_next  = ST_NOTFOUND;
                    oid_next  = '0;
                    ourg_next = 1'b0;
                end
            end
            else
            begin
                ctrl.op  = OP_STEP;
                cnt_next = cnt_reg - 1'b1;
            end
        end
        else if (accept)
        begin
            ov_next   = 1'b1;
            ost_next  = ST_OK;
            oid_next  = '0;
            ourg_next = 1'b0;
            case (in_req)
                REQ_ADD:
                begin
                    if (full)
                    begin
                        ost_next = ST_FULL;
                    end
                    else
                    begin
                        ctrl.op  = (in_urg && !empty) ? OP_PUSH_FRONT : OP_PUSH_REAR;
                        occ_next = occ_reg + 1'b1;
                    end
                end
                REQ_SERVE:
                begin
                    if (empty)
                    begin
                        ost_next = ST_EMPTY;
                    end
                    else
                    begin
                        ctrl.op   = OP_POP;
                        occ_next  = occ_reg - 1'b1;
                        oid_next  = c_id[0];
                        ourg_next = c_urg[0];
                    end
                end
                REQ_SEARCH:
                begin
                    if (empty)
                    begin
                        ost_next = ST_EMPTY;
                    end
                    else
                    begin
                        ctrl.op    = OP_LOAD;
                        ov_next    = 1'b0;
                        key_next   = in_id;
                        cnt_next   = IDX_W'(occ_reg - 1'b1);
                        state_next = S_WALK;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            occ_reg   <= '0;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        ost_reg  <= ost_next;
        oid_reg  <= oid_next;
        ourg_reg <= ourg_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {{(TDATA_W - ID_W - STATUS_W - 1){1'b0}}, ourg_reg, oid_reg, ost_reg};

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(DEPTH))
        else $error("Occupancy exceeds the queue depth.");

    a_walk_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> !ov_reg)
        else $error("A search is in progress while a result is pending.");

    a_serve_dec: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_req == REQ_SERVE) && !empty) |=> (occ_reg == $past(occ_reg) - 1'b1))
        else $error("A serve did not remove one entry.");

    a_walk_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (!accept && (occ_reg != '0)))
        else $error("A request was taken during a search, or the queue emptied.");
endmodule
`default_nettype wire

### sim/tcdq_result_checker.sv
// Checker for the two-class deque: predicts each request's result and compares it on the output.
`timescale 1ns / 100ps
module tcdq_result_checker #(
    parameter int DEPTH = tcdq_pkg::DEPTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_tvalid,
    input  wire logic                         s_tready,
    input  wire logic [tcdq_pkg::TDATA_W-1:0] s_tdata,
    input  wire logic                         m_tvalid,
    input  wire logic                         m_tready,
    input  wire logic [tcdq_pkg::TDATA_W-1:0] m_tdata,
    output int                                failures,
    output int                                outstanding,
    output int                                results
);
    import tcdq_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     id;
        logic                urg;
    } outcome_t;

    outcome_t        pending_outcomes[$];
    logic [ID_W-1:0] slot_id [DEPTH];
    logic            slot_urg [DEPTH];
    int              front;
    int              fill;

    function automatic outcome_t deque_apply(input logic [REQ_W-1:0] req,
                                             input logic [ID_W-1:0] id,
                                             input logic urg);
        outcome_t r;
        int       pos;
        bit       hit;
        r = '0;
        hit = 1'b0;
        case (req)
            REQ_ADD:
                if (fill >= DEPTH) begin
                    r.status = ST_FULL;
                end
                else begin
                    if (urg) begin
                        front = (front + DEPTH - 1) % DEPTH;
                        pos = front;
                    end
                    else begin
                        pos = (front + fill) % DEPTH;
                    end
                    slot_id[pos] = id;
                    slot_urg[pos] = urg;
                    fill++;
                end
            REQ_SERVE:
                if (fill == 0) begin
                    r.status = ST_EMPTY;
                end
                else begin
                    r.id = slot_id[front];
                    r.urg = slot_urg[front];
                    front = (front + 1) % DEPTH;
                    fill--;
                end
            REQ_SEARCH:
                if (fill == 0) begin
                    r.status = ST_EMPTY;
                end
                else begin
                    r.status = ST_NOTFOUND;
                    for (int k = 0; k < fill; k++) begin
                        pos = (front + k) % DEPTH;
                        if (!hit && slot_id[pos] == id) begin
                            hit = 1'b1;
                            r.status = ST_OK;
                            r.id = slot_id[pos];
                            r.urg = slot_urg[pos];
                        end
                    end
                end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        outcome_t want;
        if (!rst_n) begin
            pending_outcomes.delete();
            front = 0;
            fill = 0;
            outstanding = 0;
        end
        else begin
            if (m_tvalid && m_tready) begin
                results++;
                if (pending_outcomes.size() == 0) begin
                    $error("result with no request waiting: tdata %h", m_tdata);
                    failures++;
                end
                else begin
                    want = pending_outcomes.pop_front();
                    if (m_tdata[1:0] !== want.status) begin
                        $error("status expected %0d actual %0d", want.status, m_tdata[1:0]);
                        failures++;
                    end
                    if (m_tdata[33:2] !== want.id) begin
                        $error("out_id expected %0d actual %0d",
                               $signed(want.id), $signed(m_tdata[33:2]));
                        failures++;
                    end
                    if (m_tdata[34] !== want.urg) begin
                        $error("out_urgent expected %0d actual %0d", want.urg, m_tdata[34]);
                        failures++;
                    end
                    if (m_tdata[TDATA_W-1:35] !== '0) begin
                        $error("zero fill expected 0 actual %0h", m_tdata[TDATA_W-1:35]);
                        failures++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                pending_outcomes.push_back(deque_apply(s_tdata[1:0], s_tdata[33:2], s_tdata[34]));
            end
            outstanding = pending_outcomes.size();
        end
    end
endmodule

### sim/tb_two_class_deque_with_id_search.sv
// Testbench top for the two-class deque: clock, reset, request and result traffic, and verdict.
`timescale 1ns / 100ps
module tb_two_class_deque_with_id_search;
    import tcdq_pkg::*;

    localparam int               DEPTH        = DEPTH_DEF;
    localparam logic [REQ_W-1:0] REQ_RESERVED = 2'd3;
    localparam int               HOLD_CYCLES  = 300;
    localparam int               TARGET       = 1350;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;

    int failures;
    int outstanding;
    int results;
    int pace;
    bit hold_request;
    int sent;
    int sent_by_type [4];

    two_class_deque_with_id_search #(.DEPTH(DEPTH)) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    tcdq_result_checker #(.DEPTH(DEPTH)) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .failures   (failures),
        .outstanding(outstanding),
        .results    (results)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic int draw_gap();
        case (pace)
            0:       return 0;
            1:       return $urandom_range(0, 3);
            default: return $urandom_range(0, 15);
        endcase
    endfunction

    task automatic send_request(input logic [REQ_W-1:0] req, input logic [ID_W-1:0] id,
                                input logic urg);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(TDATA_W - 35){1'b0}}, urg, id, req};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sent++;
        sent_by_type[req]++;
    endtask

    task automatic run_phase(input int count, input int add_pct, input int serve_pct);
        logic [ID_W-1:0]  id_pool [8];
        logic [REQ_W-1:0] req;
        logic [ID_W-1:0]  id;
        int               roll;
        foreach (id_pool[i]) id_pool[i] = $urandom;
        id_pool[0] = ($urandom_range(0, 1) == 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        repeat (count) begin
            roll = $urandom_range(0, 99);
            if (roll < 3)
                req = REQ_RESERVED;
            else if (roll < 3 + add_pct)
                req = REQ_ADD;
            else if (roll < 3 + add_pct + serve_pct)
                req = REQ_SERVE;
            else
                req = REQ_SEARCH;
            id = ($urandom_range(0, 3) == 0) ? $urandom : id_pool[$urandom_range(0, 7)];
            send_request(req, id, 1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        int stall;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever begin
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            stall = draw_gap();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    initial
    begin
        #10_000_000;
        $display("two_class_deque_with_id_search: mismatch");
        $finish;
    end

    initial
    begin
        int phase;
        int style;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        pace = 2;
        hold_request = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(REQ_SERVE, 32'h0, 1'b0);
        send_request(REQ_SEARCH, 32'h8000_0000, 1'b1);
        send_request(REQ_RESERVED, 32'hFFFF_FFFF, 1'b1);
        // An urgent entry into an empty queue, then both ends with the id extremes.
        send_request(REQ_ADD, 32'hFFFF_FFFF, 1'b1);
        send_request(REQ_ADD, 32'h8000_0000, 1'b0);
        send_request(REQ_ADD, 32'h7FFF_FFFF, 1'b1);
        send_request(REQ_ADD, 32'h0, 1'b0);
        send_request(REQ_SEARCH, 32'h0, 1'b0);
        send_request(REQ_SEARCH, 32'h1234_5678, 1'b0);
        send_request(REQ_SERVE, 32'h0, 1'b0);
        for (int i = 0; i < 13; i++) begin
            send_request(REQ_ADD, i * 32'h1111_1111, ~i[0]);
        end
        send_request(REQ_ADD, 32'h5555_5555, 1'b1);
        send_request(REQ_ADD, 32'hAAAA_AAAA, 1'b0);
        send_request(REQ_RESERVED, 32'h0, 1'b0);
        send_request(REQ_SEARCH, 32'h0, 1'b0);

        phase = 0;
        while (sent < TARGET) begin
            pace = $urandom_range(0, 2);
            if (phase == 3) begin
                hold_request = 1'b1;
            end
            style = $urandom_range(0, 3);
            case (style)
                0:       run_phase($urandom_range(30, 60), 70, 10);
                1:       run_phase($urandom_range(30, 60), 15, 65);
                2:       run_phase($urandom_range(30, 60), 30, 20);
                default: run_phase($urandom_range(30, 60), 40, 30);
            endcase
            phase++;
        end
        s_tvalid <= 1'b0;

        @(posedge clk);
        wait (outstanding == 0);
        repeat (40) @(posedge clk);
        $display("Sent %0d requests: %0d adds, %0d serves, %0d searches, %0d reserved.",
                 sent, sent_by_type[REQ_ADD], sent_by_type[REQ_SERVE],
                 sent_by_type[REQ_SEARCH], sent_by_type[REQ_RESERVED]);
        $display("Checked %0d results over %0d traffic phases, one with a long result stall.",
                 results, phase);
        if (failures == 0 && outstanding == 0)
            $display("two_class_deque_with_id_search: match");
        else
            $display("two_class_deque_with_id_search: mismatch");
        $finish;
    end
endmodule
